[hdl/bmsc_pkg.sv]
// ----------------------------------------------------------------------------
// bmsc_pkg
// Shared codes, character constants and types for the brace matcher.
// ----------------------------------------------------------------------------
package bmsc_pkg;

  localparam int unsigned CharBits = 16;
  localparam int unsigned ModeBits = 3;
  localparam int unsigned OutOffBits = 16;

  // lexer modes
  localparam logic [ModeBits-1:0] MODE_NORMAL     = 3'd0;
  localparam logic [ModeBits-1:0] MODE_SLASH      = 3'd1;
  localparam logic [ModeBits-1:0] MODE_LINE       = 3'd2;
  localparam logic [ModeBits-1:0] MODE_BLOCK      = 3'd3;
  localparam logic [ModeBits-1:0] MODE_BLOCK_STAR = 3'd4;
  localparam logic [ModeBits-1:0] MODE_QUOTE      = 3'd5;
  localparam logic [ModeBits-1:0] MODE_QUOTE_ESC  = 3'd6;
  localparam logic [ModeBits-1:0] MODE_DONE       = 3'd7;

  // character codes
  localparam logic [CharBits-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CharBits-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CharBits-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CharBits-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CharBits-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CharBits-1:0] CH_STAR   = 16'h002A;
  localparam logic [CharBits-1:0] CH_SLASH  = 16'h002F;
  localparam logic [CharBits-1:0] CH_NL     = 16'h000A;

  localparam logic [OutOffBits-1:0] OUT_OFF_MAX = 16'hFFFF;

  typedef struct packed {
    logic emit;
    logic found;
  } lex_res_t;

endpackage

[hdl/brace_matcher_skipping_comments.sv]
// ----------------------------------------------------------------------------
// brace_matcher_skipping_comments
// Finds the brace that closes the one at the search start, skipping comments,
// strings and character literals.
// ----------------------------------------------------------------------------
// Takes one 16-bit code unit per cycle and keeps that rate without gaps as
// long as the result side takes its item when offered. Every character passes
// an input register, combinational lexer logic that updates mode, depth and
// offset, and a result register, in that order. A search gives at most one
// result: the closing brace offset, or not-found at the character flagged as
// the end. Characters after a result are dropped until the next start flag.
module brace_matcher_skipping_comments #(
  parameter int unsigned DEPTH_BITS  = 16,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bmsc_pkg::CharBits-1:0]   char_code_i,
  input  logic                            start_flag_i,
  input  logic                            end_flag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [bmsc_pkg::OutOffBits-1:0] match_offset_o
);
  import bmsc_pkg::*;

  logic                         in_vld_q, in_vld_d;
  logic [CharBits-1:0]          char_q;
  logic                         start_q;
  logic                         end_q;
  logic                         advance;
  logic                         in_acc;

  logic [ModeBits-1:0]          mode_q, mode_d;
  logic                         quote_q, quote_d;
  logic signed [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [OFFSET_BITS-1:0]       offset_q, offset_d;
  lex_res_t                     res;

  logic                         out_vld_q, out_vld_d;
  logic                         found_q;
  logic [OutOffBits-1:0]        moff_q, moff_d;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vld_d   = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  bmsc_lex #(
    .DEPTH_BITS (DEPTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lex (
    .char_code_i (char_q),
    .start_flag_i(start_q),
    .end_flag_i  (end_q),
    .mode_i      (mode_q),
    .quote_dbl_i (quote_q),
    .depth_i     (depth_q),
    .offset_i    (offset_q),
    .mode_o      (mode_d),
    .quote_dbl_o (quote_d),
    .depth_o     (depth_d),
    .offset_o    (offset_d),
    .res_o       (res)
  );

  // offset as reported: saturated or widened to the output width
  if (OFFSET_BITS > OutOffBits) begin : g_off_sat
    assign moff_d = (|offset_q[OFFSET_BITS-1:OutOffBits]) ? OUT_OFF_MAX
                                                          : offset_q[OutOffBits-1:0];
  end else begin : g_off_ext
    assign moff_d = OutOffBits'(offset_q);
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    if (advance && res.emit) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_NORMAL;
      quote_q   <= 1'b0;
      depth_q   <= '0;
      offset_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        mode_q   <= mode_d;
        quote_q  <= quote_d;
        depth_q  <= depth_d;
        offset_q <= offset_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q  <= char_code_i;
      start_q <= start_flag_i;
      end_q   <= end_flag_i;
    end
    if (advance && res.emit) begin
      found_q <= res.found;
      moff_q  <= res.found ? moff_d : '0;
    end
  end

  // the reported offset is the offset register at the closing brace; a hit does not increment it
  assign out_valid_o    = out_vld_q;
  assign found_o        = found_q;
  assign match_offset_o = moff_q;

endmodule

[hdl/bmsc_lex.sv]
// ----------------------------------------------------------------------------
// bmsc_lex
// One-character lexer step: next mode, quote kind, depth and offset, and the result flags.
// ----------------------------------------------------------------------------
module bmsc_lex #(
  parameter int unsigned DEPTH_BITS  = 16,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic [bmsc_pkg::CharBits-1:0] char_code_i,
  input  logic                          start_flag_i,
  input  logic                          end_flag_i,
  input  logic [bmsc_pkg::ModeBits-1:0] mode_i,
  input  logic                          quote_dbl_i,
  input  logic signed [DEPTH_BITS-1:0]  depth_i,
  input  logic [OFFSET_BITS-1:0]        offset_i,
  output logic [bmsc_pkg::ModeBits-1:0] mode_o,
  output logic                          quote_dbl_o,
  output logic signed [DEPTH_BITS-1:0]  depth_o,
  output logic [OFFSET_BITS-1:0]        offset_o,
  output bmsc_pkg::lex_res_t            res_o
);
  import bmsc_pkg::*;

  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [OFFSET_BITS-1:0]       OffMax   = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0]       OffOne   = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  logic [ModeBits-1:0]          mode_c;
  logic                         quote_c;
  logic signed [DEPTH_BITS-1:0] depth_c;
  logic [OFFSET_BITS-1:0]       offset_c;
  logic                         plain;
  logic                         hit;
  logic [CharBits-1:0]          close_ch;

  always_comb begin
    // start clears the search state before the character is looked at
    mode_c   = start_flag_i ? MODE_NORMAL : mode_i;
    quote_c  = start_flag_i ? 1'b0 : quote_dbl_i;
    depth_c  = start_flag_i ? '0 : depth_i;
    offset_c = start_flag_i ? '0 : offset_i;

    mode_o      = mode_c;
    quote_dbl_o = quote_c;
    depth_o     = depth_c;
    offset_o    = offset_c;
    plain       = 1'b0;
    hit         = 1'b0;
    close_ch    = quote_c ? CH_DQUOTE : CH_SQUOTE;
    res_o       = '0;

    case (mode_c)
      MODE_SLASH: begin
        if (char_code_i == CH_SLASH) begin
          mode_o = MODE_LINE;
        end else if (char_code_i == CH_STAR) begin
          mode_o = MODE_BLOCK;
        end else begin
          mode_o = MODE_NORMAL;
          plain  = 1'b1;
        end
      end
      MODE_LINE: begin
        if (char_code_i == CH_NL) mode_o = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (char_code_i == CH_STAR) mode_o = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (char_code_i == CH_SLASH) begin
          mode_o = MODE_NORMAL;
        end else if (char_code_i != CH_STAR) begin
          mode_o = MODE_BLOCK;
        end
      end
      MODE_QUOTE: begin
        if (char_code_i == CH_BSLASH) begin
          mode_o = MODE_QUOTE_ESC;
        end else if (char_code_i == close_ch) begin
          mode_o = MODE_NORMAL;
        end
      end
      MODE_QUOTE_ESC: mode_o = MODE_QUOTE;
      MODE_DONE:      mode_o = MODE_DONE;
      default:        plain = 1'b1;
    endcase

    if (plain) begin
      if (char_code_i == CH_SLASH) begin
        mode_o = MODE_SLASH;
      end else if (char_code_i == CH_DQUOTE || char_code_i == CH_SQUOTE) begin
        mode_o      = MODE_QUOTE;
        quote_dbl_o = (char_code_i == CH_DQUOTE);
      end else if (char_code_i == CH_LBRACE) begin
        if (depth_c != DepthMax) depth_o = depth_c + DepthOne;
      end else if (char_code_i == CH_RBRACE) begin
        if (depth_c != DepthMin) depth_o = depth_c - DepthOne;
        hit = (depth_o == '0);
      end
    end

    if (mode_c != MODE_DONE) begin
      if (hit) begin
        mode_o    = MODE_DONE;
        res_o     = '{emit: 1'b1, found: 1'b1};
      end else begin
        if (offset_c != OffMax) offset_o = offset_c + OffOne;
        if (end_flag_i) begin
          mode_o = MODE_DONE;
          res_o  = '{emit: 1'b1, found: 1'b0};
        end
      end
    end
  end

endmodule

[hdl/bmsc_checker.sv]
// ----------------------------------------------------------------------------
// bmsc_checker
// Port-level checks for the brace matcher, bound to the top level.
// ----------------------------------------------------------------------------
module bmsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [bmsc_pkg::CharBits-1:0]   char_code_i,
  input logic                            start_flag_i,
  input logic                            end_flag_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            found_o,
  input logic [bmsc_pkg::OutOffBits-1:0] match_offset_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
                                    && $stable(match_offset_o))
    else $error("result item changed while stalled");

  // not-found carries a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("not-found item with nonzero offset");

  // input only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // a rise of result valid implies that it was low before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(out_valid_o))
    else $error("result valid rose unexpectedly");

endmodule

bind brace_matcher_skipping_comments bmsc_checker u_bmsc_checker (.*);
